[design/maf_pkg.sv]
// Shared constants, types and codes for the moving/exponential average filter.
`default_nettype none

package maf_pkg;

   // Field and storage widths
   localparam int SAMPLE_W   = 16;
   localparam int MAX_WINDOW = 256;
   localparam int SLOT_W     = $clog2(MAX_WINDOW);
   localparam int WIN_W      = 9;
   localparam int MIX_W      = 17;
   localparam int SUM_W      = SAMPLE_W + SLOT_W;
   localparam int DIV_STEPS  = SUM_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int MUL_A_W    = MIX_W + 1;
   localparam int MUL_B_W    = SAMPLE_W + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int FRAC_W     = 16;
   localparam int IDX_W      = 2;

   // Register reset values and limits
   localparam logic [MIX_W-1:0] MIX_ONE     = MIX_W'(1 << FRAC_W);
   localparam logic [MIX_W-1:0] MIX_RESET   = MIX_W'(1 << (FRAC_W - 1));
   localparam logic [WIN_W-1:0] WIN_MIN     = WIN_W'(2);
   localparam logic [WIN_W-1:0] WIN_MAX     = WIN_W'(MAX_WINDOW);
   localparam logic [WIN_W-1:0] WIN_RESET   = WIN_W'(2);

   // Register indexes on the csr port
   typedef enum logic [IDX_W-1:0] {
      CSR_MODE   = 2'd0,
      CSR_WINDOW = 2'd1,
      CSR_MIX    = 2'd2
   } csr_index_type;

   // Filter modes
   typedef enum logic {
      MODE_MOVING = 1'b0,
      MODE_EXP    = 1'b1
   } mode_type;

   // Operations of the shared arithmetic unit
   typedef enum logic {
      OP_DIV = 1'b0,
      OP_MUL = 1'b1
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

[design/maf_unit.sv]
// Shared arithmetic unit: serial restoring divider and registered multiplier.
`default_nettype none

module maf_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire maf_pkg::unit_cmd_type                 cmd,
   input  wire logic signed [maf_pkg::SUM_W-1:0]      div_num,
   input  wire logic        [maf_pkg::WIN_W-1:0]      div_den,
   input  wire logic signed [maf_pkg::MUL_A_W-1:0]    mul_a,
   input  wire logic signed [maf_pkg::MUL_B_W-1:0]    mul_b,
   output maf_pkg::unit_status_type                   status,
   output logic signed [maf_pkg::SAMPLE_W-1:0]        quot,
   output logic signed [maf_pkg::PROD_W-1:0]          prod
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [maf_pkg::STEP_W-1:0]          cnt_ff, cnt_in;
   logic [maf_pkg::SUM_W-1:0]           acc_ff, acc_in;
   logic [maf_pkg::WIN_W-1:0]           rem_ff, rem_in;
   logic [maf_pkg::WIN_W-1:0]           den_ff, den_in;
   logic                                neg_ff, neg_in;
   logic signed [maf_pkg::PROD_W-1:0]   prod_ff, prod_in;

   logic [maf_pkg::WIN_W:0]             trial;
   logic                                fits;
   logic [maf_pkg::SUM_W-1:0]           quot_full;

   // One quotient bit per step: shift the next dividend bit into the remainder
   always_comb begin
      trial = {rem_ff, acc_ff[maf_pkg::SUM_W-1]};
      fits  = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      if (cmd.start) begin
         unique case (cmd.op)
            maf_pkg::OP_MUL: begin
               prod_in = maf_pkg::PROD_W'(mul_a) * maf_pkg::PROD_W'(mul_b);
               done_in = 1'b1;
            end
            maf_pkg::OP_DIV: begin
               busy_in = 1'b1;
               cnt_in  = '0;
               neg_in  = div_num[maf_pkg::SUM_W-1];
               acc_in  = div_num[maf_pkg::SUM_W-1] ? maf_pkg::SUM_W'(-div_num)
                                                    : maf_pkg::SUM_W'(div_num);
               rem_in  = '0;
               den_in  = div_den;
            end
         endcase
      end else if (busy_ff) begin
         rem_in = fits ? maf_pkg::WIN_W'(trial - {1'b0, den_ff})
                       : trial[maf_pkg::WIN_W-1:0];
         acc_in = {acc_ff[maf_pkg::SUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == maf_pkg::STEP_W'(maf_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
   end

   // Quotient magnitude gets the dividend's sign back: truncation toward zero
   assign quot_full   = neg_ff ? maf_pkg::SUM_W'(-acc_ff) : acc_ff;
   assign quot        = quot_full[maf_pkg::SAMPLE_W-1:0];
   assign prod        = prod_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

[design/moving_or_exponential_average_filter_top.sv]
// Top level: sequencer, history memory, running sum and output register.
// Sequence: moving average goes IDLE, MEM, SUM, then DIV and DONE once the
//   window is full, with no result while it fills; exponential: IDLE, MUL, DONE.
// Input is taken only in IDLE, so a new sample waits until the last result is
//   in the output register; the serial divider makes one quotient bit per cycle.
// Reset: synchronous, active high; clears control, configuration, sums and the
//   output valid flag; history memory is not cleared and needs no clearing pass.
`default_nettype none

module moving_or_exponential_average_filter_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input stream
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [maf_pkg::SAMPLE_W-1:0]  req_tdata,   // [15:0] sample
   input  wire logic                          req_tuser,   // [0] first
   // result stream
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [maf_pkg::SAMPLE_W-1:0]       rsp_tdata,   // [15:0] smoothed
   // configuration
   input  wire logic                          csr_we,
   input  wire logic [maf_pkg::IDX_W-1:0]     csr_index,
   input  wire logic [maf_pkg::MIX_W-1:0]     csr_wdata
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MEM  = 6'b000010,
      S_SUM  = 6'b000100,
      S_DIV  = 6'b001000,
      S_MUL  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type                               state_ff, state_in;
   maf_pkg::mode_type                       mode_ff, mode_in;
   logic [maf_pkg::WIN_W-1:0]               window_ff, window_in;
   logic [maf_pkg::MIX_W-1:0]               mix_ff, mix_in;
   logic signed [maf_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [maf_pkg::WIN_W-1:0]               fill_ff, fill_in;
   logic [maf_pkg::SLOT_W-1:0]              slot_ff, slot_in;
   logic signed [maf_pkg::SAMPLE_W-1:0]     prev_ff, prev_in;
   logic signed [maf_pkg::SAMPLE_W-1:0]     x_ff, x_in;
   logic signed [maf_pkg::SAMPLE_W-1:0]     res_ff, res_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [maf_pkg::SAMPLE_W-1:0]            rsp_data_ff, rsp_data_in;
   logic signed [maf_pkg::SAMPLE_W-1:0]     hist_rd_ff;
   logic signed [maf_pkg::SAMPLE_W-1:0]     hist_mem [maf_pkg::MAX_WINDOW];

   logic                                    in_xfer;
   logic                                    out_load;
   logic [maf_pkg::WIN_W-1:0]               eff_w;
   logic [maf_pkg::SLOT_W-1:0]              slot_eff;
   logic [maf_pkg::WIN_W-1:0]               slot_next;
   logic                                    full_old;
   logic [maf_pkg::MIX_W-1:0]               mix_sat;
   logic signed [maf_pkg::MUL_B_W-1:0]      diff;
   logic signed [maf_pkg::SAMPLE_W+2:0]     ema_sum;

   maf_pkg::unit_cmd_type                   unit_cmd;
   maf_pkg::unit_status_type                unit_status;
   logic signed [maf_pkg::SAMPLE_W-1:0]     unit_quot;
   logic signed [maf_pkg::PROD_W-1:0]       unit_prod;

   assign req_tready = (state_ff == S_IDLE);
   assign in_xfer    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Effective window, clamped to 2..MAX_WINDOW
   always_comb begin
      if (window_ff < maf_pkg::WIN_MIN) begin
         eff_w = maf_pkg::WIN_MIN;
      end else if (window_ff > maf_pkg::WIN_MAX) begin
         eff_w = maf_pkg::WIN_MAX;
      end else begin
         eff_w = window_ff;
      end
   end

   // Delay line slot bookkeeping
   assign slot_eff  = ({1'b0, slot_ff} >= eff_w) ? '0 : slot_ff;
   assign slot_next = {1'b0, slot_eff} + 1'b1;
   assign full_old  = (fill_ff >= eff_w);

   // Exponential mix: y = prev + floor(m * (x - prev) / 2^16)
   assign mix_sat = (mix_ff > maf_pkg::MIX_ONE) ? maf_pkg::MIX_ONE : mix_ff;
   assign diff    = maf_pkg::MUL_B_W'(signed'(req_tdata)) - maf_pkg::MUL_B_W'(prev_ff);
   assign ema_sum = (maf_pkg::SAMPLE_W+3)'(prev_ff)
                    + unit_prod[maf_pkg::PROD_W-1:maf_pkg::FRAC_W];

   // Start commands for the shared unit
   always_comb begin
      unit_cmd.start = 1'b0;
      unit_cmd.op    = maf_pkg::OP_DIV;
      if (in_xfer && (mode_ff == maf_pkg::MODE_EXP)) begin
         unit_cmd.start = 1'b1;
         unit_cmd.op    = maf_pkg::OP_MUL;
      end else if ((state_ff == S_SUM) && (fill_in >= eff_w)) begin
         unit_cmd.start = 1'b1;
         unit_cmd.op    = maf_pkg::OP_DIV;
      end
   end

   maf_unit u_unit (
      .clock   (clock),
      .reset   (reset),
      .cmd     (unit_cmd),
      .div_num (sum_in),
      .div_den (eff_w),
      .mul_a   (signed'({1'b0, mix_sat})),
      .mul_b   (diff),
      .status  (unit_status),
      .quot    (unit_quot),
      .prod    (unit_prod)
   );

   // Sequencer and state update
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      window_in    = window_ff;
      mix_in       = mix_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      prev_in      = prev_ff;
      x_in         = x_ff;
      res_in       = res_ff;
      out_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (in_xfer) begin
               x_in = signed'(req_tdata);
               if (req_tuser) begin
                  sum_in  = '0;
                  fill_in = '0;
                  slot_in = '0;
               end
               state_in = (mode_ff == maf_pkg::MODE_EXP) ? S_MUL : S_MEM;
            end
         end
         S_MEM: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            sum_in  = sum_ff + maf_pkg::SUM_W'(x_ff)
                      - (full_old ? maf_pkg::SUM_W'(hist_rd_ff) : '0);
            slot_in = (slot_next >= eff_w) ? '0 : slot_next[maf_pkg::SLOT_W-1:0];
            fill_in = full_old ? fill_ff : fill_ff + 1'b1;
            state_in = (fill_in >= eff_w) ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            if (unit_status.done) begin
               res_in   = unit_quot;
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            if (unit_status.done) begin
               res_in   = (fill_ff == '0) ? x_ff : ema_sum[maf_pkg::SAMPLE_W-1:0];
               prev_in  = res_in;
               fill_in  = maf_pkg::WIN_W'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register writes; mode and window restart the signal
      if (csr_we) begin
         unique case (csr_index)
            maf_pkg::CSR_MODE: begin
               mode_in = maf_pkg::mode_type'(csr_wdata[0]);
               sum_in  = '0;
               fill_in = '0;
               slot_in = '0;
            end
            maf_pkg::CSR_WINDOW: begin
               window_in = csr_wdata[maf_pkg::WIN_W-1:0];
               sum_in    = '0;
               fill_in   = '0;
               slot_in   = '0;
            end
            maf_pkg::CSR_MIX: begin
               mix_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= maf_pkg::MODE_MOVING;
         window_ff    <= maf_pkg::WIN_RESET;
         mix_ff       <= maf_pkg::MIX_RESET;
         sum_ff       <= '0;
         fill_ff      <= '0;
         slot_ff      <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         window_ff    <= window_in;
         mix_ff       <= mix_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // History delay line: oldest sample read out as the new one goes in
   always_ff @(posedge clock) begin
      if (state_ff == S_MEM) begin
         hist_rd_ff         <= hist_mem[slot_eff];
         hist_mem[slot_eff] <= x_ff;
      end
   end

`ifndef SYNTHESIS
   // Fill count never passes the active window
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_w)
      else $error("fill count exceeds window");

   // Write slot stays inside the active window
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, slot_ff} < eff_w)
      else $error("write slot outside window");

   // Exponential mode only tracks whether a previous output exists
   a_exp_fill: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == maf_pkg::MODE_EXP) |-> (fill_ff <= maf_pkg::WIN_W'(1)))
      else $error("exponential fill count above one");

   // Unit completes only while the sequencer waits for it
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      unit_status.done |-> ((state_ff == S_DIV) || (state_ff == S_MUL)))
      else $error("unit completion with no waiting state");

   // No new input while the divider is running
   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      unit_status.busy |-> !req_tready)
      else $error("input ready while divider busy");
`endif

endmodule

`default_nettype wire

[bench/tb_moving_or_exponential_average_filter_top.sv]
// Self-checking testbench for the moving/exponential average filter top level.
`default_nettype none

module tb_moving_or_exponential_average_filter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import maf_pkg::*;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 8;
   localparam int SETTLE_CYCLES   = 40;    // longer than the moving-average latency
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASE_COUNT     = 6;
   localparam logic [IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // Directed table rows: either a register write or one sample
   typedef enum logic {
      ROW_SAMPLE = 1'b0,
      ROW_CSR    = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [IDX_W-1:0]      idx;        // CSR rows only
      logic [MIX_W-1:0]      wdata;      // CSR rows only
      logic [SAMPLE_W-1:0]   smp;
      logic                  first_flag;
      logic                  known;      // 1: known_val is the expected output
      logic [SAMPLE_W-1:0]   known_val;
   } directed_row_type;

   localparam int DIRECTED_N = 29;
   localparam directed_row_type DIRECTED_ROWS [0:DIRECTED_N-1] = '{
      // moving average, window 2 after reset
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h7FFF, 1'b1, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h8000, 1'b0, 1'b1, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h8000, 1'b0, 1'b1, 16'h8000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h0001, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h1234, 1'b1, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h0002, 1'b0, 1'b0, 16'h0000},
      // window below the minimum acts as 2
      '{ROW_CSR,    CSR_WINDOW, 17'd0,       16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h0005, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'hFFF9, 1'b0, 1'b1, 16'hFFFF},
      // odd window, quotient rounds toward zero
      '{ROW_CSR,    CSR_WINDOW, 17'd3,       16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h0100, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h0200, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h0301, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h8000, 1'b0, 1'b0, 16'h0000},
      // exponential: first sample passes, floor rounding
      '{ROW_CSR,    CSR_MODE,   17'd1,       16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h8000, 1'b0, 1'b1, 16'h8000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h7FFF, 1'b0, 1'b1, 16'hFFFF},
      // zero weight holds the previous output
      '{ROW_CSR,    CSR_MIX,    17'd0,       16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h7FFF, 1'b0, 1'b1, 16'hFFFF},
      // weight above one saturates
      '{ROW_CSR,    CSR_MIX,    17'h1FFFF,   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h1357, 1'b0, 1'b1, 16'h1357},
      '{ROW_CSR,    CSR_MIX,    17'h10000,   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h8000, 1'b1, 1'b1, 16'h8000},
      // unknown index is ignored, no restart
      '{ROW_CSR,    CSR_UNUSED_INDEX, 17'h1FFFF, 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h4000, 1'b0, 1'b1, 16'h4000},
      '{ROW_CSR,    CSR_MIX,    17'd1,       16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, CSR_MODE,   17'd0,       16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR,    CSR_MODE,   17'd0,       16'h0000, 1'b0, 1'b0, 16'h0000}
   };

   // DUT ports
   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [SAMPLE_W-1:0]  req_tdata;    // [15:0] sample
   logic                 req_tuser;    // [0] first
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [SAMPLE_W-1:0]  rsp_tdata;    // [15:0] smoothed
   logic                 csr_we;
   logic [IDX_W-1:0]     csr_index;
   logic [MIX_W-1:0]     csr_wdata;

   // Filter model state
   mode_type             cfg_mode;
   logic [WIN_W-1:0]     cfg_window;
   logic [MIX_W-1:0]     cfg_mix;
   logic [SAMPLE_W-1:0]  hist_mem [0:MAX_WINDOW-1];
   longint               acc_sum;
   int unsigned          fill_cnt;
   int unsigned          slot_ptr;
   longint               prev_smoothed;

   // Expected outputs, oldest first
   logic [SAMPLE_W-1:0]  smoothed_q [$];
   logic [SAMPLE_W-1:0]  want_smoothed;

   int                   error_count = 0;
   int                   idle_cycles = 0;
   int                   send_idle_pct = 0;
   int                   stall_pct = 0;
   logic                 hold_off_pending = 1'b0;

   moving_or_exponential_average_filter_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD/2) clock = ~clock;

   // Restart of the signal: new window, exponential passes next sample
   function automatic void clear_window_state();
      acc_sum  = 0;
      fill_cnt = 0;
      slot_ptr = 0;
   endfunction

   // Advance the filter model by one sample; returns 1 when an output is due
   function automatic bit filter_step(input logic [SAMPLE_W-1:0] smp, input bit first_flag,
                                      output logic [SAMPLE_W-1:0] smoothed);
      longint      x;
      longint      m;
      longint      mix_sum;
      longint      y;
      int unsigned w;
      int unsigned s;
      x = longint'($signed(smp));
      smoothed = '0;
      if (first_flag)
         clear_window_state();
      if (cfg_mode == MODE_MOVING) begin
         w = (cfg_window < WIN_MIN) ? WIN_MIN : (cfg_window > WIN_MAX) ? WIN_MAX : cfg_window;
         s = (slot_ptr >= w) ? 0 : slot_ptr;
         if (fill_cnt >= w)
            acc_sum -= longint'($signed(hist_mem[s]));
         hist_mem[s] = smp;
         acc_sum += x;
         s++;
         slot_ptr = (s >= w) ? 0 : s;
         if (fill_cnt < w)
            fill_cnt++;
         if (fill_cnt < w)
            return 1'b0;
         // signed division truncates toward zero
         smoothed = SAMPLE_W'(acc_sum / longint'(w));
         return 1'b1;
      end
      if (fill_cnt == 0) begin
         y = x;
      end else begin
         m = (cfg_mix > MIX_ONE) ? longint'(MIX_ONE) : longint'(cfg_mix);
         mix_sum = m * x + (longint'(MIX_ONE) - m) * prev_smoothed;
         y = mix_sum >>> FRAC_W;   // floor
      end
      fill_cnt = 1;
      prev_smoothed = y;
      smoothed = SAMPLE_W'(y);
      return 1'b1;
   endfunction

   // Register write, model updated alongside
   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [MIX_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MODE: begin
            cfg_mode = mode_type'(val[0]);
            clear_window_state();
         end
         CSR_WINDOW: begin
            cfg_window = val[WIN_W-1:0];
            clear_window_state();
         end
         CSR_MIX: begin
            cfg_mix = val;
         end
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   // One sample transfer on the input stream, with random idle before it
   task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit first_flag,
                              input bit known, input logic [SAMPLE_W-1:0] known_val);
      logic [SAMPLE_W-1:0] predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tuser  <= first_flag;
      do begin
         @(posedge clock);
      end while (!req_tready);
      if (filter_step(smp, first_flag, predicted))
         smoothed_q.insert(smoothed_q.size(), known ? known_val : predicted);
      @(negedge clock);
   endtask

   // Stop offering, wait for all outputs, then let the block settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (smoothed_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Sample values biased toward the extremes and toward zero
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return SAMPLE_W'($urandom_range(8)) - 16'd4;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Output side: random stalls, long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_pending = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Compare each output transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (smoothed_q.size() == 0) begin
            $display("%0t: unexpected output: expected none, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want_smoothed = smoothed_q.pop_front();
            if (rsp_tdata !== want_smoothed) begin
               $display("%0t: smoothed mismatch: expected %h, actual %h",
                        $time, want_smoothed, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("Verification failed");
         $finish;
      end
   end

   // Stimulus
   initial begin
      int           ph;
      int           n;
      int           first_pct;
      mode_type     ph_mode;
      logic [WIN_W-1:0] ph_window;
      logic [MIX_W-1:0] ph_mix;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_MODE;
      csr_wdata  = '0;

      cfg_mode   = MODE_MOVING;
      cfg_window = WIN_RESET;
      cfg_mix    = MIX_RESET;
      prev_smoothed = 0;
      clear_window_state();

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      for (int r = 0; r < DIRECTED_N; r++) begin
         if (DIRECTED_ROWS[r].kind == ROW_CSR) begin
            wait_drained();
            csr_write(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].wdata);
         end else begin
            send_sample(DIRECTED_ROWS[r].smp, DIRECTED_ROWS[r].first_flag,
                        DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].known_val);
         end
      end

      // Random phases, each with its own settings and idle pattern
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_drained();
         ph_mix    = MIX_W'($urandom);
         ph_window = WIN_RESET;
         first_pct = 4;
         n = 25;
         case (ph)
            0: begin
               ph_mode = MODE_MOVING;
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               ph_mode = MODE_MOVING;
               ph_window = WIN_W'($urandom_range(16, 3));
               send_idle_pct = 62;
               stall_pct = 0;
            end
            2: begin
               ph_mode = MODE_EXP;
               ph_mix = MIX_W'($urandom_range(32'h10000, 0));
               send_idle_pct = 0;
               stall_pct = 62;
            end
            3: begin
               ph_mode = MODE_EXP;
               ph_mix = MIX_W'($urandom_range(32'h1FFFF, 32'h10001));
               send_idle_pct = 7;
               stall_pct = 7;
            end
            4: begin
               ph_mode = MODE_MOVING;
               ph_window = WIN_W'($urandom_range(8, 2));
               send_idle_pct = 0;
               stall_pct = 0;
               n = 40;
            end
            default: begin
               // largest window; a value past the limit acts as the limit
               ph_mode = MODE_MOVING;
               ph_window = $urandom_range(1) ? WIN_MAX : 9'h1FF;
               send_idle_pct = 7;
               stall_pct = 7;
               first_pct = 0;
               n = 300;
            end
         endcase
         csr_write(CSR_MIX, ph_mix);
         csr_write(CSR_WINDOW, MIX_W'(ph_window));
         csr_write(CSR_MODE, MIX_W'(ph_mode));
         // output held off while the input keeps offering
         if (ph == 4)
            hold_off_pending = 1'b1;
         for (int i = 0; i < n; i++)
            send_sample(pick_sample(), $urandom_range(99) < first_pct, 1'b0, '0);
      end

      wait_drained();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
